// ===== hdl/ict_pkg.sv =====
// shared types, constants and the arctangent table of the tilt filter
package ict_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ANGLE_W = 26;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DEF_ANGLE_FRAC_BITS = 16;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int SQRT_STEPS = 16;
    localparam int ATAN_IDX_W = 5;
    localparam logic [15:0] BLEND_RESET = 16'd65208;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_X_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_Y_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_AXIS = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic square;
        logic sqrt_step;
        logic cordic_load;
        logic cordic_step;
        logic conv;
        logic mul;
        logic acc;
        logic out_load;
    } ict_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic sqrt_last;
        logic cordic_last;
        logic out_free;
    } ict_sts_t;

    // atan(2^-i) in binary angle units, 2^32 is a full turn
    function automatic logic [31:0] atan_bin(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0: v = 32'h20000000;
            5'd1: v = 32'h12E4051E;
            5'd2: v = 32'h09FB385B;
            5'd3: v = 32'h051111D4;
            5'd4: v = 32'h028B0D43;
            5'd5: v = 32'h0145D7E1;
            5'd6: v = 32'h00A2F61E;
            5'd7: v = 32'h00517C55;
            5'd8: v = 32'h0028BE53;
            5'd9: v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/ict_if.sv =====
// sample and result channel interfaces of the tilt filter

interface ict_in_if;
    logic valid;
    logic ready;
    logic signed [ict_pkg::SAMPLE_W-1:0] accel_x;
    logic signed [ict_pkg::SAMPLE_W-1:0] accel_y;
    logic signed [ict_pkg::SAMPLE_W-1:0] accel_z;
    logic signed [ict_pkg::SAMPLE_W-1:0] gyro_x;
    logic signed [ict_pkg::SAMPLE_W-1:0] gyro_y;
    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, output ready);
endinterface

interface ict_out_if;
    logic valid;
    logic ready;
    logic signed [ict_pkg::ANGLE_W-1:0] roll_angle;
    logic signed [ict_pkg::ANGLE_W-1:0] pitch_angle;
    logic signed [ict_pkg::ANGLE_W-1:0] tilt_angle;
    modport source (output valid, roll_angle, pitch_angle, tilt_angle, input ready);
    modport sink (input valid, roll_angle, pitch_angle, tilt_angle, output ready);
endinterface

// ===== hdl/ict_ctrl.sv =====
// sequencing state machine of the tilt filter
module ict_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ict_pkg::ict_sts_t sts,
    output ict_pkg::ict_cmd_t cmd
);
    import ict_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SQUARE = 9'b000000010,
        ST_SQRT   = 9'b000000100,
        ST_LOAD   = 9'b000001000,
        ST_CORDIC = 9'b000010000,
        ST_CONV   = 9'b000100000,
        ST_MUL    = 9'b001000000,
        ST_ACC    = 9'b010000000,
        ST_WRITE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.cordic_load = 1'b1;
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (sts.cordic_last)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ict_dp.sv =====
// datapath: magnitude root, two cordic lanes, gyro blend and result register
module ict_dp #(
    parameter int ANGLE_FRAC_BITS = ict_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STEPS = ict_pkg::DEF_CORDIC_STEPS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ict_pkg::ict_cmd_t                      cmd,
    output ict_pkg::ict_sts_t                      sts,
    input  logic                                   cfg_we,
    input  logic [ict_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ict_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic signed [ict_pkg::SAMPLE_W-1:0]    accel_x,
    input  logic signed [ict_pkg::SAMPLE_W-1:0]    accel_y,
    input  logic signed [ict_pkg::SAMPLE_W-1:0]    accel_z,
    input  logic signed [ict_pkg::SAMPLE_W-1:0]    gyro_x,
    input  logic signed [ict_pkg::SAMPLE_W-1:0]    gyro_y,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [ict_pkg::ANGLE_W-1:0]     roll_angle,
    output logic signed [ict_pkg::ANGLE_W-1:0]     pitch_angle,
    output logic signed [ict_pkg::ANGLE_W-1:0]     tilt_angle
);
    import ict_pkg::*;

    localparam int ITER_MAX = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
    localparam int CNT_W = $clog2(ITER_MAX);
    localparam int SH = 29 - ANGLE_FRAC_BITS;
    localparam logic signed [50:0] EST_MAX = 51'sd33554431;
    localparam logic signed [50:0] EST_MIN = -51'sd33554432;

    // configuration registers
    logic signed [15:0] off_x_reg, off_y_reg;
    logic [15:0] weight_reg;
    logic axis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= '0;
            off_y_reg <= '0;
            weight_reg <= BLEND_RESET;
            axis_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GYRO_X_OFFSET: off_x_reg <= signed'(cfg_data);
                REG_GYRO_Y_OFFSET: off_y_reg <= signed'(cfg_data);
                REG_BLEND_WEIGHT:  weight_reg <= cfg_data;
                REG_TILT_AXIS:     axis_reg <= cfg_data[0];
                default:           axis_reg <= axis_reg;
            endcase
        end
    end

    // iteration counter
    logic [CNT_W-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load_in || cmd.cordic_load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.sqrt_step || cmd.cordic_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign sts.sqrt_last = (cnt_reg == CNT_W'(SQRT_STEPS - 1));
    assign sts.cordic_last = (cnt_reg == CNT_W'(CORDIC_STEPS - 1));

    // sample capture
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            gx_reg <= gyro_x;
            gy_reg <= gyro_y;
        end
    end

    // atan2 numerators: ay for roll, -ax for pitch
    logic signed [16:0] num_r, num_p;
    assign num_r = 17'(ay_reg);
    assign num_p = -17'(ax_reg);

    // squared magnitudes and bitwise integer root, two bits a step
    logic [31:0] rem_r_reg, rem_p_reg, root_r_reg, root_p_reg;
    logic signed [31:0] sq_ax, sq_ay, sq_az;
    logic [31:0] sqrt_bit;
    logic [32:0] trial_r, trial_p;

    assign sq_ax = ax_reg * ax_reg;
    assign sq_ay = ay_reg * ay_reg;
    assign sq_az = az_reg * az_reg;
    assign sqrt_bit = 32'd1 << (5'd30 - 5'({cnt_reg[3:0], 1'b0}));
    assign trial_r = 33'(root_r_reg) + 33'(sqrt_bit);
    assign trial_p = 33'(root_p_reg) + 33'(sqrt_bit);

    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            rem_r_reg <= unsigned'(sq_ax) + unsigned'(sq_az);
            rem_p_reg <= unsigned'(sq_ay) + unsigned'(sq_az);
            root_r_reg <= '0;
            root_p_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (33'(rem_r_reg) >= trial_r)
            begin
                rem_r_reg <= rem_r_reg - trial_r[31:0];
                root_r_reg <= (root_r_reg >> 1) + sqrt_bit;
            end
            else
            begin
                root_r_reg <= root_r_reg >> 1;
            end
            if (33'(rem_p_reg) >= trial_p)
            begin
                rem_p_reg <= rem_p_reg - trial_p[31:0];
                root_p_reg <= (root_p_reg >> 1) + sqrt_bit;
            end
            else
            begin
                root_p_reg <= root_p_reg >> 1;
            end
        end
    end

    // vectoring cordic lanes, one rotation a cycle
    logic signed [39:0] x_r_reg, y_r_reg, x_p_reg, y_p_reg;
    logic signed [32:0] z_r_reg, z_p_reg;
    logic signed [32:0] atan_step;
    logic signed [39:0] dx_r, dy_r, dx_p, dy_p;

    assign atan_step = signed'({1'b0, atan_bin(ATAN_IDX_W'(cnt_reg))});
    assign dx_r = y_r_reg >>> cnt_reg;
    assign dy_r = x_r_reg >>> cnt_reg;
    assign dx_p = y_p_reg >>> cnt_reg;
    assign dy_p = x_p_reg >>> cnt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cordic_load)
        begin
            x_r_reg <= signed'({8'd0, root_r_reg[15:0], 16'd0});
            x_p_reg <= signed'({8'd0, root_p_reg[15:0], 16'd0});
            y_r_reg <= signed'({{7{num_r[16]}}, num_r, 16'd0});
            y_p_reg <= signed'({{7{num_p[16]}}, num_p, 16'd0});
            z_r_reg <= '0;
            z_p_reg <= '0;
        end
        else if (cmd.cordic_step)
        begin
            if (!y_r_reg[39])
            begin
                x_r_reg <= x_r_reg + dx_r;
                y_r_reg <= y_r_reg - dy_r;
                z_r_reg <= z_r_reg + atan_step;
            end
            else
            begin
                x_r_reg <= x_r_reg - dx_r;
                y_r_reg <= y_r_reg + dy_r;
                z_r_reg <= z_r_reg - atan_step;
            end
            if (!y_p_reg[39])
            begin
                x_p_reg <= x_p_reg + dx_p;
                y_p_reg <= y_p_reg - dy_p;
                z_p_reg <= z_p_reg + atan_step;
            end
            else
            begin
                x_p_reg <= x_p_reg - dx_p;
                y_p_reg <= y_p_reg + dy_p;
                z_p_reg <= z_p_reg - atan_step;
            end
        end
    end

    // binary angle to degrees: times 45 by shift and add, rounded shift
    logic signed [39:0] zz_r, zz_p, deg_r, deg_p;
    assign zz_r = 40'(z_r_reg);
    assign zz_p = 40'(z_p_reg);
    assign deg_r = ((zz_r <<< 5) + (zz_r <<< 3) + (zz_r <<< 2) + zz_r
                    + (40'sd1 <<< (SH - 1))) >>> SH;
    assign deg_p = ((zz_p <<< 5) + (zz_p <<< 3) + (zz_p <<< 2) + zz_p
                    + (40'sd1 <<< (SH - 1))) >>> SH;

    // gyro increment scaled to the angle format
    logic signed [16:0] d_x, d_y;
    logic signed [19:0] d5_x, d5_y;
    logic signed [47:0] inc_x, inc_y;
    assign d_x = 17'(gx_reg) - 17'(off_x_reg);
    assign d_y = 17'(gy_reg) - 17'(off_y_reg);
    assign d5_x = (20'(d_x) <<< 2) + 20'(d_x);
    assign d5_y = (20'(d_y) <<< 2) + 20'(d_y);
    assign inc_x = (48'(d5_x) <<< ANGLE_FRAC_BITS) >>> 16;
    assign inc_y = (48'(d5_y) <<< ANGLE_FRAC_BITS) >>> 16;

    // estimates and blend
    logic signed [ANGLE_W-1:0] est_r_reg, est_p_reg;
    logic signed [31:0] acc_r_reg, acc_p_reg;
    logic signed [30:0] gs_r_reg, gs_p_reg;
    logic signed [47:0] pa_r_reg, pa_p_reg;
    logic signed [48:0] pb_r_reg, pb_p_reg;
    logic signed [16:0] w_s;
    logic signed [17:0] wc_s;
    logic signed [50:0] v_r, v_p;

    // complement weight reaches 65536 when the weight is zero
    assign w_s = signed'({1'b0, weight_reg});
    assign wc_s = signed'(18'd65536 - {2'b00, weight_reg});
    assign v_r = (51'(pa_r_reg) + 51'(pb_r_reg) + 51'sd32768) >>> 16;
    assign v_p = (51'(pa_p_reg) + 51'(pb_p_reg) + 51'sd32768) >>> 16;

    always_ff @(posedge clk)
    begin
        if (cmd.conv)
        begin
            acc_r_reg <= (num_r == 17'sd0) ? 32'sd0 : deg_r[31:0];
            acc_p_reg <= (num_p == 17'sd0) ? 32'sd0 : deg_p[31:0];
            gs_r_reg <= 31'(est_r_reg) + inc_x[30:0];
            gs_p_reg <= 31'(est_p_reg) + inc_y[30:0];
        end
        if (cmd.mul)
        begin
            pa_r_reg <= w_s * gs_r_reg;
            pa_p_reg <= w_s * gs_p_reg;
            pb_r_reg <= wc_s * acc_r_reg;
            pb_p_reg <= wc_s * acc_p_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_r_reg <= '0;
            est_p_reg <= '0;
        end
        else if (cmd.acc)
        begin
            if (v_r > EST_MAX)
                est_r_reg <= EST_MAX[ANGLE_W-1:0];
            else if (v_r < EST_MIN)
                est_r_reg <= EST_MIN[ANGLE_W-1:0];
            else
                est_r_reg <= v_r[ANGLE_W-1:0];
            if (v_p > EST_MAX)
                est_p_reg <= EST_MAX[ANGLE_W-1:0];
            else if (v_p < EST_MIN)
                est_p_reg <= EST_MIN[ANGLE_W-1:0];
            else
                est_p_reg <= v_p[ANGLE_W-1:0];
        end
    end

    // result register
    logic out_valid_reg;
    logic signed [ANGLE_W-1:0] roll_reg, pitch_reg, tilt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            roll_reg <= est_r_reg;
            pitch_reg <= est_p_reg;
            tilt_reg <= axis_reg ? est_r_reg : est_p_reg;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign roll_angle = roll_reg;
    assign pitch_angle = pitch_reg;
    assign tilt_angle = tilt_reg;

endmodule

// ===== hdl/imu_complementary_tilt_filter.sv =====
// top level of the complementary roll and pitch tilt filter
//
// in_ch carries one accelerometer triple and the x and y gyro samples per
// transfer; out_ch carries roll, pitch and the selected tilt angle, degrees
// in signed fixed point with ANGLE_FRAC_BITS fraction bits.
// one item at a time: a transfer is worked up and its result loaded before
// the next transfer is taken. the root takes 16 steps, the two cordic
// lanes CORDIC_STEPS steps. the result sits in an output register, so the
// next sample is accepted while it waits; if the receiver stalls, that
// sample is worked up and then held until the register frees, and in_ch
// stays not ready meanwhile. configuration: cfg_we writes cfg_data to
// register cfg_index (0 x offset, 1 y offset, 2 blend weight, 3 tilt axis);
// the user writes only while idle, the block does not enforce it.
// reset clears both estimates and the offsets, sets the weight to 0.995
// and the tilt axis to pitch, and empties the output register.
module imu_complementary_tilt_filter #(
    parameter int ANGLE_FRAC_BITS = ict_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STEPS = ict_pkg::DEF_CORDIC_STEPS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ict_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ict_pkg::CFG_DATA_W-1:0] cfg_data,
    ict_in_if.sink                         in_ch,
    ict_out_if.source                      out_ch
);
    import ict_pkg::*;

    ict_cmd_t cmd;
    ict_sts_t sts;

    // controller
    ict_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    ict_dp #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accel_x     (in_ch.accel_x),
        .accel_y     (in_ch.accel_y),
        .accel_z     (in_ch.accel_z),
        .gyro_x      (in_ch.gyro_x),
        .gyro_y      (in_ch.gyro_y),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .roll_angle  (out_ch.roll_angle),
        .pitch_angle (out_ch.pitch_angle),
        .tilt_angle  (out_ch.tilt_angle)
    );

endmodule

// ===== bench/imu_complementary_tilt_filter_test.sv =====
// self-checking testbench of the complementary roll and pitch tilt filter
module imu_complementary_tilt_filter_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ict_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int LONG_HOLD = 300;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_PHASES = 7;

    typedef struct {
        logic signed [SAMPLE_W-1:0] ax;
        logic signed [SAMPLE_W-1:0] ay;
        logic signed [SAMPLE_W-1:0] az;
        logic signed [SAMPLE_W-1:0] gx;
        logic signed [SAMPLE_W-1:0] gy;
    } sample_t;

    typedef struct {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] tilt;
    } angles_t;

    typedef struct {
        sample_t s;
        bit      typed;
        angles_t want;
    } stim_row_t;

    typedef struct {
        logic [15:0] x_off;
        logic [15:0] y_off;
        logic [15:0] weight;
        logic [15:0] axis;
    } setting_t;

    // atan(2^-i) in binary angle units, 2^32 a full turn
    localparam longint ATAN_TAB [16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ict_in_if in_ch ();
    ict_out_if out_ch ();

    imu_complementary_tilt_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // filter model state and registers
    longint x_offset;
    longint y_offset;
    longint weight;
    bit     tilt_roll;
    longint roll_est;
    longint pitch_est;

    angles_t angle_q [$];
    int  errors;
    int  cycles;
    bit  quiet;
    bit  hold_req;
    int  hold_cnt;
    int  stall_cnt;

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // integer square root of the exact sum of squares
    function automatic longint root_floor(longint n);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'd1 << 30;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // vectoring arctangent in degrees Q16
    function automatic longint atan_deg(longint num, longint den);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        if (num == 0)
            return 0;
        x = den * 65536;
        y = num * 65536;
        z = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TAB[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TAB[i];
            end
        end
        return (z * 45 + 4096) >>> 13;
    endfunction

    // weighted mix of gyro path and accel angle, saturated
    function automatic longint mix_angle(longint est, longint inc, longint acc);
        longint v;
        v = (weight * (est + inc) + (65536 - weight) * acc + 32768) >>> 16;
        if (v > 33554431)
            v = 33554431;
        if (v < -33554432)
            v = -33554432;
        return v;
    endfunction

    // advance both estimates for one sample and return the new angles
    function automatic angles_t update_tilt(sample_t s);
        longint ax;
        longint ay;
        longint az;
        longint r_acc;
        longint p_acc;
        angles_t a;
        ax = s.ax;
        ay = s.ay;
        az = s.az;
        r_acc = atan_deg(ay, root_floor(ax * ax + az * az));
        p_acc = atan_deg(-ax, root_floor(ay * ay + az * az));
        roll_est = mix_angle(roll_est, (longint'(s.gx) - x_offset) * 5, r_acc);
        pitch_est = mix_angle(pitch_est, (longint'(s.gy) - y_offset) * 5, p_acc);
        a.roll = roll_est[ANGLE_W-1:0];
        a.pitch = pitch_est[ANGLE_W-1:0];
        a.tilt = tilt_roll ? a.roll : a.pitch;
        return a;
    endfunction

    // register write, model follows
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GYRO_X_OFFSET: x_offset = longint'($signed(data));
            REG_GYRO_Y_OFFSET: y_offset = longint'($signed(data));
            REG_BLEND_WEIGHT:  weight = longint'(data);
            REG_TILT_AXIS:     tilt_roll = data[0];
            default:           ;
        endcase
    endtask

    // offer one sample until transfer, then maybe leave a gap
    task automatic send_sample(sample_t s, bit typed, angles_t want);
        angles_t a;
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.accel_x <= s.ax;
        in_ch.accel_y <= s.ay;
        in_ch.accel_z <= s.az;
        in_ch.gyro_x <= s.gx;
        in_ch.gyro_y <= s.gy;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        a = update_tilt(s);
        angle_q.push_back(typed ? want : a);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // pause the sender until every result is back
    task automatic drain;
        in_ch.valid <= 1'b0;
        while (angle_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic sample_t rand_sample(setting_t cs);
        sample_t s;
        if ($urandom_range(0, 9) < 7)
        begin
            // plausible pose near the bias
            s.ax = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
            s.ay = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
            s.az = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
            s.gx = $signed(cs.x_off) + $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            s.gy = $signed(cs.y_off) + $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
        end
        else
        begin
            s.ax = 16'($urandom);
            s.ay = 16'($urandom);
            s.az = 16'($urandom);
            s.gx = 16'($urandom);
            s.gy = 16'($urandom);
        end
        return s;
    endfunction

    // result checker and ready pattern
    initial
    begin
        angles_t w;
        out_ch.ready = 1'b0;
        hold_cnt = 0;
        stall_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (angle_q.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    errors++;
                end
                else
                begin
                    w = angle_q.pop_front();
                    if (out_ch.roll_angle !== w.roll)
                    begin
                        $error("roll_angle expected %0d actual %0d", w.roll, out_ch.roll_angle);
                        errors++;
                    end
                    if (out_ch.pitch_angle !== w.pitch)
                    begin
                        $error("pitch_angle expected %0d actual %0d",
                               w.pitch, out_ch.pitch_angle);
                        errors++;
                    end
                    if (out_ch.tilt_angle !== w.tilt)
                    begin
                        $error("tilt_angle expected %0d actual %0d", w.tilt, out_ch.tilt_angle);
                        errors++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    stall_cnt = $urandom_range(1, 8);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        stim_row_t rows [$];
        stim_row_t r;
        setting_t  plan [NUM_PHASES];
        angles_t   none;
        errors = 0;
        cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.accel_x = '0;
        in_ch.accel_y = '0;
        in_ch.accel_z = '0;
        in_ch.gyro_x = '0;
        in_ch.gyro_y = '0;
        x_offset = 0;
        y_offset = 0;
        weight = longint'(BLEND_RESET);
        tilt_roll = 1'b0;
        roll_est = 0;
        pitch_est = 0;
        none = '{0, 0, 0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: level rest after reset reads all zero
        r = '{'{0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0}};
        rows.push_back(r);
        r.typed = 1'b0;
        r.want = none;
        // flat, gravity on z
        r.s = '{0, 0, 16'sd16384, 0, 0};            rows.push_back(r);
        // negated full scale x with zero magnitude for pitch
        r.s = '{-16'sd32768, 0, 0, 0, 0};           rows.push_back(r);
        // zero magnitude for roll, both signs
        r.s = '{0, 16'sd32767, 0, 0, 0};            rows.push_back(r);
        r.s = '{0, -16'sd32768, 0, 0, 0};           rows.push_back(r);
        // zero numerators with nonzero magnitude
        r.s = '{0, 0, -16'sd32768, 0, 0};           rows.push_back(r);
        // field extremes
        r.s = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
        rows.push_back(r);
        r.s = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
        rows.push_back(r);
        r.s = '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767};
        rows.push_back(r);
        r.s = '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768};
        rows.push_back(r);
        // steady gyro spin toward saturation
        for (int i = 0; i < 6; i++)
        begin
            r.s = '{0, 0, 16'sd16384, 16'sd32767, -16'sd32768};
            rows.push_back(r);
        end
        // tilted poses
        r.s = '{16'sd8000, -16'sd5000, 16'sd12000, 16'sd100, -16'sd100};
        rows.push_back(r);
        r.s = '{-16'sd1, 16'sd1, 16'sd1, -16'sd1, 16'sd1};
        rows.push_back(r);
        foreach (rows[i])
            send_sample(rows[i].s, rows[i].typed, rows[i].want);
        drain();

        // register settings per random phase, extremes among them
        plan[0] = '{16'd123, 16'hFF80, 16'd65208, 16'd1};
        plan[1] = '{16'h8000, 16'h7FFF, 16'd0, 16'd0};
        plan[2] = '{16'h7FFF, 16'h8000, 16'd65535, 16'd1};
        plan[3] = '{16'd0, 16'd0, 16'd32768, 16'hFFFE};
        plan[4] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        plan[5] = '{16'hFFF0, 16'd40, 16'd60000, 16'd1};
        plan[6] = '{16'd0, 16'd0, 16'd65208, 16'd0};

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_GYRO_X_OFFSET, plan[p].x_off);
            write_reg(REG_GYRO_Y_OFFSET, plan[p].y_off);
            write_reg(REG_BLEND_WEIGHT, plan[p].weight);
            write_reg(REG_TILT_AXIS, plan[p].axis);
            @(posedge clk);
            // long receiver hold fills the block while samples keep coming
            if (p == 1)
                hold_req = 1'b1;
            // last phase runs without idling
            if (p == NUM_PHASES - 1)
                quiet = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_sample(rand_sample(plan[p]), 1'b0, none);
            drain();
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
